// ===== rtl/core/pearson_correlation_defines.svh =====
// Assertion helpers for the checker file.
`ifndef PEARSON_CORRELATION_DEFINES_SVH
`define PEARSON_CORRELATION_DEFINES_SVH

// Checked at every edge, reset included.
`define PC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define PC_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/core/pc_pkg.sv =====
package pc_pkg;

    // Sample and product widths
    localparam int X_W    = 16;
    localparam int P_W    = 2 * X_W;

    // Result format: signed Q2.30
    localparam int CORR_W = 32;
    localparam int FRAC_W = 30;
    // Bits of the quotient search, one guard bit below the rounding point
    localparam int QS_W   = FRAC_W + 2;

    // Slice width of the shared multiplier
    localparam int CH_W   = 16;

    // Queue depths and default vector length limit
    localparam int ITEM_DEPTH  = 2;
    localparam int RES_DEPTH   = 2;
    localparam int MAX_LEN_DEF = 32;

    // One queued pair with its products
    typedef struct packed {
        logic [X_W-1:0] x;
        logic [X_W-1:0] y;
        logic [P_W-1:0] xx;
        logic [P_W-1:0] yy;
        logic [P_W-1:0] xy;
        logic           last;
    } t_item;

    // One finished result
    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic                     degenerate;
    } t_result;

endpackage

// ===== rtl/core/pearson_correlation.sv =====
// Pairs without the last mark: one per cycle while no evaluation runs, summed at the edge
// they leave the pair queue, up to MAX_LEN per vector. A last pair then starts eight
// products on the shared multiplier (16-bit slice per cycle) and a 32-step quotient/root
// search; only four products and no search when a variance is zero. Later pairs wait in the
// two-entry pair queue meanwhile. Results leave through a two-entry queue. Synchronous
// active-low reset empties both queues and clears the pair count and all sums.
module pearson_correlation #(
    parameter int MAX_LEN = pc_pkg::MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [pc_pkg::X_W-1:0]           i_sample_x,
    input  logic [pc_pkg::X_W-1:0]           i_sample_y,
    input  logic                             i_last,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [pc_pkg::CORR_W-1:0] o_correlation,
    output logic                             o_degenerate
);

    pc_pkg::t_item   w_item;
    logic            w_item_empty;
    logic            w_item_pop;
    pc_pkg::t_result w_res;
    logic            w_res_wr;
    logic            w_res_full;
    pc_pkg::t_result w_res_head;

    // accept side
    pc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .i_last     (i_last),
        .i_pop      (w_item_pop),
        .o_empty    (w_item_empty),
        .o_item     (w_item)
    );

    // accumulate and evaluate
    pc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_item_empty),
        .o_pop      (w_item_pop),
        .i_item     (w_item),
        .i_res_full (w_res_full),
        .o_res_wr   (w_res_wr),
        .o_res      (w_res)
    );

    // result queue
    pc_fifo #(
        .W     ($bits(pc_pkg::t_result)),
        .DEPTH (pc_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (w_res_head)
    );

    assign o_correlation = w_res_head.correlation;
    assign o_degenerate  = w_res_head.degenerate;

endmodule

// ===== rtl/core/pc_fifo.sv =====
module pc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_rd,
    output logic         o_empty,
    output logic [W-1:0] o_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // occupancy
    always_comb begin
        case ({w_wr, w_rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== rtl/core/pc_front.sv =====
module pc_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [pc_pkg::X_W-1:0]  i_sample_x,
    input  logic [pc_pkg::X_W-1:0]  i_sample_y,
    input  logic                    i_last,
    input  logic                    i_pop,
    output logic                    o_empty,
    output pc_pkg::t_item           o_item
);

    pc_pkg::t_item w_wr_item;
    pc_pkg::t_item w_rd_item;

    // Products formed on the way in, so the back end only adds
    always_comb begin
        w_wr_item.x    = i_sample_x;
        w_wr_item.y    = i_sample_y;
        w_wr_item.xx   = i_sample_x * i_sample_x;
        w_wr_item.yy   = i_sample_y * i_sample_y;
        w_wr_item.xy   = i_sample_x * i_sample_y;
        w_wr_item.last = i_last;
    end

    // Pair queue between accept side and accumulator
    pc_fifo #(
        .W     ($bits(pc_pkg::t_item)),
        .DEPTH (pc_pkg::ITEM_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (w_wr_item),
        .o_full  (o_full),
        .i_rd    (i_pop),
        .o_empty (o_empty),
        .o_rdata (w_rd_item)
    );

    assign o_item = w_rd_item;

endmodule

// ===== rtl/core/pc_mult.sv =====
module pc_mult #(
    parameter int M_W = 42
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [M_W-1:0]   i_a,
    input  logic [M_W-1:0]   i_b,
    output logic             o_done,
    output logic [2*M_W-1:0] o_prod
);

    localparam int CH_W  = pc_pkg::CH_W;
    localparam int NCH   = (M_W + CH_W - 1) / CH_W;
    localparam int K_W   = $clog2(NCH);
    localparam int B_W   = NCH * CH_W;
    localparam int ACC_W = 2 * M_W;
    localparam int PP_W  = M_W + CH_W;

    logic             r_busy;
    logic             r_done;
    logic [K_W-1:0]   r_k;
    logic [M_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [ACC_W-1:0] r_acc;
    logic [PP_W-1:0]  w_pp;
    logic             w_last;

    // one slice of b per cycle, low slice first
    assign w_pp   = r_a * r_b[CH_W-1:0];
    assign w_last = (r_k == K_W'(NCH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= B_W'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + (ACC_W'(w_pp) << (CH_W * r_k));
            r_b   <= r_b >> CH_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/core/pc_root.sv =====
module pc_root #(
    parameter int V_W = 42
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [2*V_W-1:0]        i_p,
    input  logic [2*V_W-1:0]        i_m2,
    output logic                    o_done,
    output logic [pc_pkg::QS_W-1:0] o_q
);

    // Finds the largest q with q*q*P <= M2 * 2^SH, one bit per step, high bit first.
    // A tracks q*P shifted to the current bit, B tracks P shifted to twice it.
    localparam int QS_W = pc_pkg::QS_W;
    localparam int SH   = 2 * (QS_W - 1);
    localparam int R_W  = 2 * V_W + SH;
    localparam int C_W  = $clog2(QS_W);

    logic            r_busy;
    logic            r_phase;
    logic            r_done;
    logic [C_W-1:0]  r_cnt;
    logic [R_W-1:0]  r_r;
    logic [R_W-1:0]  r_a;
    logic [R_W-1:0]  r_b;
    logic [R_W:0]    r_t;
    logic [QS_W-1:0] r_q;
    logic [R_W+1:0]  w_diff;
    logic            w_ge;

    assign w_diff = {2'b00, r_r} - {1'b0, r_t};
    assign w_ge   = !w_diff[R_W+1];

    // step control: phase 0 forms the trial term, phase 1 compares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= C_W'(QS_W - 1);
            end else if (r_busy) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // remainder and running terms
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= R_W'(i_m2) << SH;
            r_b <= R_W'(i_p) << SH;
            r_a <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_t <= {1'b0, r_a} + {1'b0, r_b};
            end else begin
                if (w_ge) begin
                    r_r <= w_diff[R_W-1:0];
                    r_a <= (r_a >> 1) + r_b;
                end else begin
                    r_a <= r_a >> 1;
                end
                r_b <= r_b >> 2;
                r_q <= {r_q[QS_W-2:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ===== rtl/core/pc_back.sv =====
module pc_back #(
    parameter int MAX_LEN = pc_pkg::MAX_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  pc_pkg::t_item   i_item,
    input  logic            i_res_full,
    output logic            o_res_wr,
    output pc_pkg::t_result o_res
);

    localparam int LOG_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int S1_W   = pc_pkg::X_W + LOG_W;
    localparam int S2_W   = pc_pkg::P_W + LOG_W;
    localparam int V_W    = pc_pkg::P_W + 2 * LOG_W;
    localparam int QS_W   = pc_pkg::QS_W;
    localparam int CORR_W = pc_pkg::CORR_W;
    localparam logic [QS_W-1:0] ONE_Q = QS_W'(1) << pc_pkg::FRAC_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_RWAIT = 3'd4;
    localparam logic [2:0] ST_SIGN  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // product steps of the final evaluation
    localparam logic [2:0] OP_NXX = 3'd0;
    localparam logic [2:0] OP_SXX = 3'd1;
    localparam logic [2:0] OP_NYY = 3'd2;
    localparam logic [2:0] OP_SYY = 3'd3;
    localparam logic [2:0] OP_NXY = 3'd4;
    localparam logic [2:0] OP_SXY = 3'd5;
    localparam logic [2:0] OP_VV  = 3'd6;
    localparam logic [2:0] OP_MM  = 3'd7;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [2:0]       r_op;
    logic [2:0]       n_op;
    logic [CNT_W-1:0] r_cnt;
    logic [S1_W-1:0]  r_sx;
    logic [S1_W-1:0]  r_sy;
    logic [S2_W-1:0]  r_sxx;
    logic [S2_W-1:0]  r_syy;
    logic [S2_W-1:0]  r_sxy;
    logic [V_W-1:0]   r_t0;
    logic [V_W-1:0]   r_vx;
    logic [V_W-1:0]   r_vy;
    logic [V_W:0]     r_num;
    logic             r_neg;
    logic [V_W-1:0]   r_mag;
    logic [2*V_W-1:0] r_p;
    logic [2*V_W-1:0] r_m2;
    logic [QS_W-1:0]  r_qr;
    pc_pkg::t_result  r_res;

    logic [V_W-1:0]    w_mul_a;
    logic [V_W-1:0]    w_mul_b;
    logic              w_mul_start;
    logic              w_mul_done;
    logic [2*V_W-1:0]  w_prod;
    logic [V_W-1:0]    w_prod_lo;
    logic              w_root_start;
    logic              w_root_done;
    logic [QS_W-1:0]   w_q;
    logic [QS_W:0]     w_q1;
    logic [QS_W-1:0]   w_qc;
    logic [CORR_W-1:0] w_mag_c;
    logic [CORR_W-1:0] w_corr;
    logic [V_W:0]      w_num;
    logic [V_W:0]      w_abs;
    logic [V_W-1:0]    w_n;
    logic              w_add;
    logic              w_degen;

    assign w_n       = V_W'(r_cnt);
    assign w_add     = (r_cnt < CNT_W'(MAX_LEN));
    assign w_degen   = (r_vx == '0) || (r_vy == '0);
    assign w_prod_lo = w_prod[V_W-1:0];
    assign w_num     = {1'b0, r_t0} - {1'b0, w_prod_lo};
    assign w_abs     = r_num[V_W] ? ('0 - r_num) : r_num;
    assign w_q1      = {1'b0, w_q} + {{QS_W{1'b0}}, 1'b1};
    assign w_qc      = (r_qr > ONE_Q) ? ONE_Q : r_qr;
    assign w_mag_c   = CORR_W'(w_qc);
    assign w_corr    = r_neg ? ('0 - w_mag_c) : w_mag_c;

    // multiplier operands per step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_op)
            OP_NXX: begin w_mul_a = w_n;              w_mul_b = V_W'(r_sxx); end
            OP_SXX: begin w_mul_a = V_W'(r_sx);       w_mul_b = V_W'(r_sx);  end
            OP_NYY: begin w_mul_a = w_n;              w_mul_b = V_W'(r_syy); end
            OP_SYY: begin w_mul_a = V_W'(r_sy);       w_mul_b = V_W'(r_sy);  end
            OP_NXY: begin w_mul_a = w_n;              w_mul_b = V_W'(r_sxy); end
            OP_SXY: begin w_mul_a = V_W'(r_sx);       w_mul_b = V_W'(r_sy);  end
            OP_VV:  begin w_mul_a = r_vx;             w_mul_b = r_vy;        end
            OP_MM:  begin w_mul_a = r_mag;            w_mul_b = r_mag;       end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        o_pop        = 1'b0;
        o_res_wr     = 1'b0;
        w_mul_start  = 1'b0;
        w_root_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop = !i_empty;
                if (!i_empty && i_item.last) begin
                    n_state = ST_MUL;
                    n_op    = OP_NXX;
                end
            end
            ST_MUL: begin
                if (r_op == OP_NXY && w_degen) begin
                    n_state = ST_OUT;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_mul_done) begin
                    if (r_op == OP_MM) begin
                        n_state = ST_ROOT;
                    end else begin
                        n_op    = r_op + 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_ROOT: begin
                w_root_start = 1'b1;
                n_state      = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (w_root_done) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_res_wr = !i_res_full;
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, count and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_NXX;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (o_pop && w_add) begin
                r_cnt <= r_cnt + 1'b1;
                r_sx  <= r_sx + S1_W'(i_item.x);
                r_sy  <= r_sy + S1_W'(i_item.y);
                r_sxx <= r_sxx + S2_W'(i_item.xx);
                r_syy <= r_syy + S2_W'(i_item.yy);
                r_sxy <= r_sxy + S2_W'(i_item.xy);
            end
            // vector done: start over
            if (o_res_wr) begin
                r_cnt <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxx <= '0;
                r_syy <= '0;
                r_sxy <= '0;
            end
        end
    end

    // intermediate terms of the final evaluation
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WAIT && w_mul_done) begin
            case (r_op) inside
                OP_NXX, OP_NYY, OP_NXY: r_t0 <= w_prod_lo;
                OP_SXX: r_vx  <= r_t0 - w_prod_lo;
                OP_SYY: r_vy  <= r_t0 - w_prod_lo;
                OP_SXY: r_num <= w_num;
                OP_VV: begin
                    r_p   <= w_prod;
                    r_neg <= r_num[V_W];
                    r_mag <= w_abs[V_W-1:0];
                end
                OP_MM:  r_m2  <= w_prod;
            endcase
        end
        // round half up on the guard bit
        if (r_state == ST_RWAIT && w_root_done) begin
            r_qr <= w_q1[QS_W:1];
        end
        if (r_state == ST_MUL && r_op == OP_NXY && w_degen) begin
            r_res.correlation <= '0;
            r_res.degenerate  <= 1'b1;
        end
        if (r_state == ST_SIGN) begin
            r_res.correlation <= w_corr;
            r_res.degenerate  <= 1'b0;
        end
    end

    assign o_res = r_res;

    // shared multiplier
    pc_mult #(
        .M_W (V_W)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // quotient over the square root
    pc_root #(
        .V_W (V_W)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_p     (r_p),
        .i_m2    (r_m2),
        .o_done  (w_root_done),
        .o_q     (w_q)
    );

endmodule

// ===== rtl/core/pc_checker.sv =====
`include "pearson_correlation_defines.svh"

module pc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic signed [pc_pkg::CORR_W-1:0] o_correlation,
    input logic                             o_degenerate
);

    // reset empties the result queue and leaves room in the pair queue
    `PC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty, "result queue not empty after reset")
    `PC_ASSERT_ALWAYS(a_rst_room, i_clk, !i_rst_n |=> !full, "pair queue full after reset")

    // a degenerate result carries zero
    `PC_ASSERT_RUN(a_degen_zero, i_clk, i_rst_n, (!empty && o_degenerate) |-> (o_correlation == '0), "degenerate result with nonzero correlation")

    // coefficient stays within plus or minus one
    `PC_ASSERT_RUN(a_range, i_clk, i_rst_n, !empty |-> ((o_correlation <= 32'sd1073741824) && (o_correlation >= -32'sd1073741824)), "correlation out of range")

    // a waiting result holds until taken
    `PC_ASSERT_RUN(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_correlation) && $stable(o_degenerate)), "waiting result changed")

endmodule

bind pearson_correlation pc_checker u_pc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_correlation (o_correlation),
    .o_degenerate  (o_degenerate)
);

// ===== tb/sv/pearson_correlation_tb.sv =====
module pearson_correlation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VEC_CAP       = pc_pkg::MAX_LEN_DEF;
    // No beat in either direction for this long means the block is stuck
    localparam int STALL_LIMIT   = 4000;
    // Give any extra results room to show up after the last drain
    localparam int SETTLE_CYCLES = 300;

    typedef logic [pc_pkg::X_W-1:0] t_sample;
    typedef t_sample t_vec[$];

    // Flavors of random vector content
    typedef enum int {
        MIX_FREE,
        MIX_NARROW,
        MIX_LINEAR,
        MIX_FLAT,
        MIX_RAILS
    } t_mix;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             push;
    logic                             full;
    logic [pc_pkg::X_W-1:0]           i_sample_x;
    logic [pc_pkg::X_W-1:0]           i_sample_y;
    logic                             i_last;
    logic                             empty;
    logic                             pop;
    logic signed [pc_pkg::CORR_W-1:0] o_correlation;
    logic                             o_degenerate;

    always #6 i_clk = ~i_clk;

    pearson_correlation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_last        (i_last),
        .empty         (empty),
        .pop           (pop),
        .o_correlation (o_correlation),
        .o_degenerate  (o_degenerate)
    );

    // Running sums mirrored from the accepted pairs
    int unsigned     pair_cnt = 0;
    longint unsigned sum_x    = 0;
    longint unsigned sum_y    = 0;
    longint unsigned sum_xx   = 0;
    longint unsigned sum_yy   = 0;
    longint unsigned sum_xy   = 0;

    pc_pkg::t_result corr_due[$];
    int      err_cnt       = 0;
    int      items_sent    = 0;
    int      vectors_sent  = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    // Exact Pearson coefficient in Q2.30 from the current sums
    function automatic pc_pkg::t_result pearson_of_sums();
        longint unsigned n, vx, vy, mag, q, cand;
        longint          num;
        bit              neg;
        bit [255:0]      w_var, w_rhs, w_lhs, w_a;
        int              b;
        pc_pkg::t_result r;
        r.correlation = '0;
        r.degenerate  = 1'b0;
        n  = 64'(pair_cnt);
        vx = n * sum_xx - sum_x * sum_x;
        vy = n * sum_yy - sum_y * sum_y;
        if (vx == 0 || vy == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        num = longint'(n * sum_xy) - longint'(sum_x * sum_y);
        neg = (num < 0);
        mag = neg ? longint'(0) - num : num;
        // Product of the variance terms, and mag^2 scaled by 2^62
        w_var = 256'(vx);
        w_a   = 256'(vy);
        w_var = w_var * w_a;
        w_rhs = 256'(mag);
        w_rhs = (w_rhs * w_rhs) << 62;
        // Largest q with q^2 * var <= rhs, one guard bit below Q30
        q = 0;
        for (b = pc_pkg::QS_W - 1; b >= 0; b--) begin
            cand  = q | (64'd1 << b);
            w_a   = 256'(cand);
            w_lhs = w_a * w_a * w_var;
            if (w_lhs <= w_rhs)
                q = cand;
        end
        q = (q + 1) >> 1;
        if (q > (64'd1 << pc_pkg::FRAC_W))
            q = 64'd1 << pc_pkg::FRAC_W;
        r.correlation = neg ? 32'(64'd0 - q) : 32'(q);
        return r;
    endfunction

    // Fold one pair into the sums; returns 1 when it closes a vector
    function automatic bit absorb_pair(input t_sample x, input t_sample y, input logic fin,
                                       output pc_pkg::t_result r);
        longint unsigned wx, wy;
        wx = 64'(x);
        wy = 64'(y);
        r  = '0;
        if (pair_cnt < VEC_CAP) begin
            pair_cnt++;
            sum_x  += wx;
            sum_y  += wy;
            sum_xx += wx * wx;
            sum_yy += wy * wy;
            sum_xy += wx * wy;
        end
        if (!fin)
            return 1'b0;
        r        = pearson_of_sums();
        pair_cnt = 0;
        sum_x    = 0;
        sum_y    = 0;
        sum_xx   = 0;
        sum_yy   = 0;
        sum_xy   = 0;
        return 1'b1;
    endfunction

    // One input beat, with optional idle cycles ahead of it
    task automatic send_pair(input t_sample x, input t_sample y, input logic fin);
        pc_pkg::t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push       = 1'b1;
        i_sample_x = x;
        i_sample_y = y;
        i_last     = fin;
        do @(posedge i_clk); while (full);
        if (absorb_pair(x, y, fin, r)) begin
            corr_due = {corr_due, r};
            vectors_sent++;
        end
        items_sent++;
    endtask

    task automatic send_vector(input t_vec xs, input t_vec ys);
        int k;
        for (k = 0; k < xs.size(); k++)
            send_pair(xs[k], ys[k], k == xs.size() - 1);
    endtask

    // Stop sending until every predicted result has been popped
    task automatic drain_results();
        @(negedge i_clk);
        push = 1'b0;
        while (corr_due.size() != 0)
            @(posedge i_clk);
    endtask

    // A single pair has no variance
    task automatic test_single_pair();
        send_vector('{16'h0000}, '{16'hFFFF});
        send_vector('{16'hFFFF}, '{16'h0000});
    endtask

    // A flat vector on either side forces the degenerate flag
    task automatic test_flat_vector();
        send_vector('{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'h0000, 16'h0001, 16'hFFFF});
        send_vector('{16'h0000, 16'h0007, 16'hFFFF}, '{16'h0000, 16'h0000, 16'h0000});
    endtask

    // Full-scale swings: exactly plus one, minus one, and a mixed case
    task automatic test_full_scale();
        send_vector('{16'h0000, 16'hFFFF}, '{16'h0000, 16'hFFFF});
        send_vector('{16'h0000, 16'hFFFF}, '{16'hFFFF, 16'h0000});
        send_vector('{16'd1, 16'd2, 16'd3, 16'd40000}, '{16'hFFFF, 16'd12, 16'd300, 16'd9});
    endtask

    // Pairs past the length cap are dropped, the last one still closes the vector
    task automatic test_overlong_vector();
        int k;
        for (k = 0; k < VEC_CAP + 4; k++) begin
            if (k >= VEC_CAP)
                send_pair(16'hFFFF, 16'h0000, k == VEC_CAP + 3);
            else
                send_pair(t_sample'($urandom), t_sample'($urandom), 1'b0);
        end
        for (k = 0; k < VEC_CAP; k++)
            send_pair(t_sample'($urandom), t_sample'($urandom), k == VEC_CAP - 1);
    endtask

    task automatic send_random_vector();
        int      len, k, pick;
        t_mix    mix;
        t_sample base_x, base_y, x, y;
        pick = $urandom_range(99);
        if (pick < 8)
            len = 1;
        else if (pick < 14)
            len = $urandom_range(VEC_CAP - 2, VEC_CAP + 6);
        else
            len = $urandom_range(2, 12);
        mix    = t_mix'($urandom_range(MIX_RAILS));
        base_x = t_sample'($urandom);
        base_y = t_sample'($urandom);
        for (k = 0; k < len; k++) begin
            case (mix)
                MIX_FREE: begin
                    x = t_sample'($urandom);
                    y = t_sample'($urandom);
                end
                MIX_NARROW: begin
                    x = base_x ^ t_sample'($urandom_range(15));
                    y = base_y + t_sample'($urandom_range(31));
                end
                MIX_LINEAR: begin
                    x = t_sample'($urandom);
                    y = (base_y[0] ? ~x : x) ^ t_sample'($urandom_range(3));
                end
                MIX_FLAT: begin
                    x = base_y[1] ? base_x : t_sample'($urandom);
                    y = base_y[1] ? t_sample'($urandom) : base_y;
                end
                default: begin
                    x = $urandom_range(1) ? '1 : '0;
                    y = $urandom_range(1) ? '1 : '0;
                end
            endcase
            send_pair(x, y, k == len - 1);
        end
    endtask

    // Random vectors under one idle setting
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
        int first_item, first_vec;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_item    = items_sent;
        first_vec     = vectors_sent;
        while (items_sent - first_item < n_items || vectors_sent - first_vec < 15)
            send_random_vector();
    endtask

    // Compare one popped beat against the oldest prediction
    task automatic check_result();
        pc_pkg::t_result want;
        if (corr_due.size() == 0) begin
            $display("%0t: unexpected result corr=%0d degenerate=%0b", $time,
                     o_correlation, o_degenerate);
            err_cnt++;
        end else begin
            want = corr_due.pop_front();
            if (o_correlation !== want.correlation) begin
                $display("%0t: correlation expected %0d got %0d", $time,
                         want.correlation, o_correlation);
                err_cnt++;
            end
            if (o_degenerate !== want.degenerate) begin
                $display("%0t: degenerate expected %0b got %0b", $time,
                         want.degenerate, o_degenerate);
                err_cnt++;
            end
        end
    endtask

    // Result side: random pop, checked at the rising edge
    initial begin
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            pop = ($urandom_range(99) >= recv_idle_pct);
            @(posedge i_clk);
            if (pop && !empty)
                check_result();
        end
    end

    // Watchdog on cycles without any beat
    initial begin
        int idle_run;
        idle_run = 0;
        wait (i_rst_n === 1'b1);
        while (idle_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_sample_x = '0;
        i_sample_y = '0;
        i_last     = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 78;
        test_single_pair();
        test_flat_vector();
        test_full_scale();
        test_overlong_vector();

        test_random_phase(31, 78, 120);
        drain_results();
        test_random_phase(78, 31, 120);
        drain_results();
        test_random_phase(0, 0, 120);

        // Wait out the tail, then watch for stray results
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
